FILE: design/nca_pkg.sv
// Shared constants, beat types and controller/datapath signal groups.
package nca_pkg;

	// Frame size and coordinate format
	localparam int NUM_OBJECTS = 6;
	localparam int COORD_BITS  = 16;

	// Derived widths
	localparam int IDX_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W   = 2 * COORD_BITS + 1;
	localparam int DIST_W = SQ_W + 2;

	// Fixed field widths of the beats
	localparam int FIELD_W  = 16;
	localparam int OUT_ID_W = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OBJECTS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [DIST_W-1:0] dist_t;

	// Input beat: one cluster centre
	typedef struct packed {
		logic signed [FIELD_W-1:0] center_x;
		logic signed [FIELD_W-1:0] center_y;
		logic signed [FIELD_W-1:0] center_z;
	} item_t;

	// Result beat: one association
	typedef struct packed {
		logic [OUT_ID_W-1:0] tracker_index;
		logic [OUT_ID_W-1:0] object_id;
		logic                last_of_frame;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // item beat taken this cycle
		logic to_stored; // first frame: write tracker centre
		idx_t slot;
		logic issue;     // distance pair enters the pipeline
		idx_t trk;
		idx_t obj;
		logic wb;        // write-back of one tracker slot
		idx_t wb_idx;
	} nca_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_empty;
	} nca_stat_t;

	// Sign-correct coordinate from a raw field (low COORD_BITS bits)
	function automatic coord_t to_coord(input logic [FIELD_W-1:0] raw);
		to_coord = coord_t'(COORD_BITS'(raw));
	endfunction

endpackage

FILE: design/nca_ctrl.sv
// Controller: frame slot tracking, search sequencing and write-back sequencing.
module nca_ctrl
	import nca_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output nca_cmd_t  cmd,
	input  nca_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	state_t state_q;
	idx_t   slot_q;
	logic   first_q;
	idx_t   trk_q;
	idx_t   obj_q;
	idx_t   wb_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Commands decoded from state and counters
	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.to_stored = first_q;
		cmd.slot      = slot_q;
		cmd.issue     = (state_q == ST_SEARCH);
		cmd.trk       = trk_q;
		cmd.obj       = obj_q;
		cmd.wb        = (state_q == ST_WRITE);
		cmd.wb_idx    = wb_q;
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			first_q <= 1'b1;
			trk_q   <= '0;
			obj_q   <= '0;
			wb_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
						if (slot_q == LAST_IDX) begin
							if (first_q) begin
								first_q <= 1'b0;
							end else begin
								trk_q   <= '0;
								obj_q   <= '0;
								state_q <= ST_SEARCH;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (obj_q == LAST_IDX) begin
						obj_q <= '0;
						if (trk_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end else begin
							trk_q <= trk_q + 1'b1;
						end
					end else begin
						obj_q <= obj_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last tracker's choice is settled once the pipe is empty
					if (stat.pipe_empty) begin
						wb_q    <= '0;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wb_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						wb_q <= wb_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/nca_datapath.sv
// Datapath: centre stores, distance pipeline, nearest search and result register.
module nca_datapath
	import nca_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item,
	input  nca_cmd_t  cmd,
	output nca_stat_t stat,
	output logic      result_valid,
	output result_t   result
);

	// Centre stores (x, y, z)
	coord_t trk_x_q [NUM_OBJECTS];
	coord_t trk_y_q [NUM_OBJECTS];
	coord_t trk_z_q [NUM_OBJECTS];
	coord_t frm_x_q [NUM_OBJECTS];
	coord_t frm_y_q [NUM_OBJECTS];
	coord_t frm_z_q [NUM_OBJECTS];
	idx_t   chosen_q [NUM_OBJECTS];

	// Pipeline registers
	logic                     vld_s1, vld_s2, vld_s3;
	idx_t                     trk_s1, trk_s2, trk_s3;
	idx_t                     obj_s1, obj_s2, obj_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	dist_t                    dist_s3;

	// Running minimum for the current tracker
	dist_t best_d_q;
	idx_t  best_id_q;

	logic signed [PROD_W-1:0] px, py, pz;
	logic                     take;
	idx_t                     pick;

	assign stat.pipe_empty = !(vld_s1 || vld_s2 || vld_s3);

	// Store writes: capture of a beat, then the post-search write-back
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (cmd.to_stored) begin
				trk_x_q[cmd.slot] <= to_coord(item.center_x);
				trk_y_q[cmd.slot] <= to_coord(item.center_y);
				trk_z_q[cmd.slot] <= '0;
			end else begin
				frm_x_q[cmd.slot] <= to_coord(item.center_x);
				frm_y_q[cmd.slot] <= to_coord(item.center_y);
				frm_z_q[cmd.slot] <= to_coord(item.center_z);
			end
		end
		if (cmd.wb && (int'(chosen_q[cmd.wb_idx]) < NUM_OBJECTS)) begin
			trk_x_q[chosen_q[cmd.wb_idx]] <= frm_x_q[cmd.wb_idx];
			trk_y_q[chosen_q[cmd.wb_idx]] <= frm_y_q[cmd.wb_idx];
			trk_z_q[chosen_q[cmd.wb_idx]] <= frm_z_q[cmd.wb_idx];
		end
	end

	// Stage 1: coordinate differences
	always_ff @(posedge clk) begin
		trk_s1 <= cmd.trk;
		obj_s1 <= cmd.obj;
		dx_s1  <= DIFF_W'(trk_x_q[cmd.trk]) - DIFF_W'(frm_x_q[cmd.obj]);
		dy_s1  <= DIFF_W'(trk_y_q[cmd.trk]) - DIFF_W'(frm_y_q[cmd.obj]);
		dz_s1  <= DIFF_W'(trk_z_q[cmd.trk]) - DIFF_W'(frm_z_q[cmd.obj]);
	end

	// Stage 2: squares, one multiplier per axis
	always_comb begin
		px = dx_s1 * dx_s1;
		py = dy_s1 * dy_s1;
		pz = dz_s1 * dz_s1;
	end

	always_ff @(posedge clk) begin
		trk_s2 <= trk_s1;
		obj_s2 <= obj_s1;
		sqx_s2 <= px[SQ_W-1:0];
		sqy_s2 <= py[SQ_W-1:0];
		sqz_s2 <= pz[SQ_W-1:0];
	end

	// Stage 3: squared distance
	always_ff @(posedge clk) begin
		trk_s3  <= trk_s2;
		obj_s3  <= obj_s2;
		dist_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Compare: strict less-than keeps the lowest index on ties
	assign take = (obj_s3 == '0) || (dist_s3 < best_d_q);
	assign pick = take ? obj_s3 : best_id_q;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			best_d_q  <= take ? dist_s3 : best_d_q;
			best_id_q <= pick;
			if (obj_s3 == LAST_IDX) begin
				chosen_q[trk_s3] <= pick;
			end
		end
		result.tracker_index <= OUT_ID_W'(trk_s3);
		result.object_id     <= OUT_ID_W'(pick);
		result.last_of_frame <= (trk_s3 == LAST_IDX);
	end

	// Result strobe: one beat per tracker, at the end of its row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s3 && (obj_s3 == LAST_IDX);
		end
	end

endmodule

FILE: design/nearest_center_association_top.sv
// Top level: nearest-centre association of cluster centres across frames.
//
// A frame is NUM_OBJECTS centre beats, taken with start while busy is low. The
// first frame only loads the tracker centres (z forced to zero) and gives no
// results. On each later frame the last beat raises busy while the
// shared squared-distance pipeline takes one tracker/centre pair per cycle,
// the three pipeline stages then drain, and the trackers are rewritten one
// slot per cycle. Other beats are taken without raising busy.
// One result strobe per tracker follows in tracker order, each valid for
// exactly one cycle; the receiver cannot stall, so it must take every beat as
// it comes.
module nearest_center_association_top
	import nca_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	nca_cmd_t  cmd;
	nca_stat_t stat;

	nca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	nca_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: test/tb_top.sv
// Testbench for nearest_center_association_top: directed and random frames against a predictor.
module tb_top;
	import nca_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_FRAMES = 40;
	localparam int IDLE_PCT      = 28;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	nearest_center_association_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	// Tracker state, association search and the queue of associations still owed
	class nearest_center_predictor;
		longint  trk_x[NUM_OBJECTS];
		longint  trk_y[NUM_OBJECTS];
		longint  trk_z[NUM_OBJECTS];
		item_t   frame_buf[NUM_OBJECTS];
		int      slot;
		bit      loading;
		result_t pending_assocs[$];
		int      fault_count;

		function new();
			slot        = 0;
			loading     = 1'b1;
			fault_count = 0;
		endfunction

		function longint sq_gap(int t, item_t c);
			longint dx, dy, dz;
			dx = trk_x[t] - longint'(c.center_x);
			dy = trk_y[t] - longint'(c.center_y);
			dz = trk_z[t] - longint'(c.center_z);
			return dx * dx + dy * dy + dz * dz;
		endfunction

		// One accepted centre beat
		function void take_center(item_t c);
			int      s, best;
			longint  d, best_d;
			int      ids[NUM_OBJECTS];
			result_t r;
			s    = slot;
			slot = (s + 1 >= NUM_OBJECTS) ? 0 : s + 1;
			// first frame only seeds the trackers, z flattened
			if (loading) begin
				trk_x[s] = longint'(c.center_x);
				trk_y[s] = longint'(c.center_y);
				trk_z[s] = 0;
				if (s == NUM_OBJECTS - 1)
					loading = 1'b0;
				return;
			end
			frame_buf[s] = c;
			if (s != NUM_OBJECTS - 1)
				return;
			// nearest centre per tracker; strict compare keeps the lowest index on a tie
			for (int t = 0; t < NUM_OBJECTS; t++) begin
				best   = 0;
				best_d = sq_gap(t, frame_buf[0]);
				for (int n = 1; n < NUM_OBJECTS; n++) begin
					d = sq_gap(t, frame_buf[n]);
					if (d < best_d) begin
						best_d = d;
						best   = n;
					end
				end
				ids[t]          = best;
				r.tracker_index = OUT_ID_W'(t);
				r.object_id     = OUT_ID_W'(best);
				r.last_of_frame = (t == NUM_OBJECTS - 1);
				pending_assocs  = {pending_assocs, r};
			end
			// write-back in ascending order, so a later centre overwrites a shared slot
			for (int t = 0; t < NUM_OBJECTS; t++) begin
				trk_x[ids[t]] = longint'(frame_buf[t].center_x);
				trk_y[ids[t]] = longint'(frame_buf[t].center_y);
				trk_z[ids[t]] = longint'(frame_buf[t].center_z);
			end
		endfunction

		// One result beat against the oldest owed association
		function void match_assoc(result_t got);
			result_t want;
			if (pending_assocs.size() == 0) begin
				$error("unexpected result beat: tracker_index %0d object_id %0d last_of_frame %0d",
					got.tracker_index, got.object_id, got.last_of_frame);
				fault_count++;
				return;
			end
			want = pending_assocs.pop_front();
			if (got.tracker_index !== want.tracker_index) begin
				$error("tracker_index: expected %0d, got %0d", want.tracker_index,
					got.tracker_index);
				fault_count++;
			end
			if (got.object_id !== want.object_id) begin
				$error("object_id: expected %0d, got %0d", want.object_id, got.object_id);
				fault_count++;
			end
			if (got.last_of_frame !== want.last_of_frame) begin
				$error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
					got.last_of_frame);
				fault_count++;
			end
		endfunction
	endclass

	nearest_center_predictor model;
	item_t prev_frame[NUM_OBJECTS];
	bit    quiet = 1'b0;
	int    cycle_count = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result monitor: every strobed beat must be taken as it comes
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			model.match_assoc(result);
	end

	function automatic item_t mk(int x, int y, int z);
		item_t c;
		c.center_x = 16'(x);
		c.center_y = 16'(y);
		c.center_z = 16'(z);
		return c;
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Random sender gaps, with junk on the item bus while start is low
	task automatic idle_gap();
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= 48'({$urandom, $urandom});
		end
	endtask

	task automatic send_center(item_t c);
		idle_gap();
		@(negedge clk);
		start <= 1'b1;
		item  <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model.take_center(c);
	endtask

	task automatic send_frame(input item_t f[NUM_OBJECTS]);
		for (int k = 0; k < NUM_OBJECTS; k++)
			send_center(f[k]);
		prev_frame = f;
	endtask

	task automatic wait_drained();
		while (model.pending_assocs.size() != 0)
			@(posedge clk);
	endtask

	// Random frame: mostly tracked motion of the last frame, plus grid, wild and extreme frames
	task automatic send_random_frame();
		item_t f[NUM_OBJECTS];
		item_t tmp;
		int    mode, step, j;
		int    extreme_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		mode = $urandom_range(9);
		for (int k = 0; k < NUM_OBJECTS; k++) begin
			if (mode < 5) begin
				step = ($urandom_range(3) == 0) ? 2048 : 64;
				f[k] = mk(
					clamp16(int'(prev_frame[k].center_x) + int'($urandom_range(2 * step)) - step),
					clamp16(int'(prev_frame[k].center_y) + int'($urandom_range(2 * step)) - step),
					clamp16(int'(prev_frame[k].center_z) + int'($urandom_range(2 * step)) - step));
			end else if (mode < 7) begin
				// coarse grid makes equal distances common
				f[k] = mk((int'($urandom_range(4)) - 2) * 256, (int'($urandom_range(4)) - 2) * 256,
					(int'($urandom_range(2)) - 1) * 256);
			end else if (mode < 9) begin
				f[k] = mk(int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)));
			end else begin
				f[k] = mk(extreme_vals[$urandom_range(6)], extreme_vals[$urandom_range(6)],
					extreme_vals[$urandom_range(6)]);
			end
		end
		// shuffle so objects change slot between frames
		for (int k = NUM_OBJECTS - 1; k > 0; k--) begin
			j    = $urandom_range(k);
			tmp  = f[k];
			f[k] = f[j];
			f[j] = tmp;
		end
		send_frame(f);
	endtask

	initial begin
		item_t f[NUM_OBJECTS];
		model = new();
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;

		// Seed frame at the corners; z must be dropped
		f = '{mk(-32768, -32768, 32767), mk(32767, 32767, -32768), mk(0, 0, 0),
			mk(32767, -32768, 0), mk(-32768, 32767, 0), mk(0, 0, -1)};
		send_frame(f);
		// All centres equal: every tracker ties and takes index 0
		f = '{mk(100, -100, 5), mk(100, -100, 5), mk(100, -100, 5),
			mk(100, -100, 5), mk(100, -100, 5), mk(100, -100, 5)};
		send_frame(f);
		// Largest distances, z at both extremes
		f = '{mk(32767, 32767, 32767), mk(-32768, -32768, -32768), mk(32767, -32768, 32767),
			mk(-32768, 32767, -32768), mk(0, 0, 32767), mk(-1, -1, -32768)};
		send_frame(f);
		// Symmetric pairs round the origin give ties between neighbours
		f = '{mk(5, 5, 0), mk(-5, -5, 0), mk(5, -5, 0), mk(-5, 5, 0), mk(0, 0, 7), mk(0, 0, -7)};
		send_frame(f);

		// Hold off until the directed results are all back
		wait_drained();

		for (int fr = 0; fr < RANDOM_FRAMES; fr++) begin
			quiet = (fr >= 12 && fr < 20);
			if (fr == 25)
				wait_drained();
			send_random_frame();
		end

		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (model.fault_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
